### rtl/nsa_pkg.sv
// nsa_pkg: shared constants, codes and types of the nfa string acceptor
// depends on nothing; imported by every module under rtl

package nsa_pkg;

	// automaton size
	localparam int N_STATES    = 16;
	localparam int NUM_SYMBOLS = 8;
	localparam int STATE_W     = $clog2(N_STATES);
	localparam int SYM_W       = $clog2(NUM_SYMBOLS);

	// fixed field widths
	localparam int CHAR_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 4;

	// reset value of the alphabet size register
	localparam logic [CFG_W-1:0] SYMS_RESET = CFG_W'(NUM_SYMBOLS);

	// input word opcodes
	typedef enum logic [1:0] {
		OP_CHAR  = 2'd0,
		OP_END   = 2'd1,
		OP_MASK  = 2'd2,
		OP_ALPHA = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMS   = 2'd2;

	// per-cell mask store write
	typedef struct packed {
		logic                  en;
		logic [SYM_W-1:0]      sym;
		logic [N_STATES-1:0]   mask;
	} mask_wr_t;

	// per-cycle step control shared by all cells
	typedef struct packed {
		logic             step;
		logic             start;
		logic             clear;
		logic             hit;
		logic [SYM_W-1:0] pos;
	} step_ctl_t;

endpackage

### rtl/nsa_alphabet.sv
// nsa_alphabet: alphabet table and character-to-symbol lookup
// depends on nsa_pkg

module nsa_alphabet (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [nsa_pkg::SYM_W-1:0]   wr_pos,
	input  logic [nsa_pkg::CHAR_W-1:0]  wr_char,
	input  logic [nsa_pkg::CHAR_W-1:0]  ch,
	input  logic [nsa_pkg::CFG_W-1:0]   count,
	output logic                        hit,
	output logic [nsa_pkg::SYM_W-1:0]   pos
);
	import nsa_pkg::*;

	logic [CHAR_W-1:0] tab_q [NUM_SYMBOLS];

	// table write, no reset: entries are undefined until loaded
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tab_q[wr_pos] <= wr_char;
		end
	end

	// lowest matching position below the alphabet size wins
	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = NUM_SYMBOLS - 1; i >= 0; i--) begin
			if (tab_q[i] == ch && i < int'(count)) begin
				hit = 1'b1;
				pos = SYM_W'(i);
			end
		end
	end

endmodule

### rtl/nsa_cell.sv
// nsa_cell: one automaton state: its active bit and its target masks
// depends on nsa_pkg; chained by nfa_string_acceptor

module nsa_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  nsa_pkg::mask_wr_t                wr,
	input  nsa_pkg::step_ctl_t               ctl,
	input  logic                             init_bit,
	input  logic [nsa_pkg::N_STATES-1:0]     union_in,
	input  logic                             fin_bit,
	output logic [nsa_pkg::N_STATES-1:0]     union_out,
	output logic                             active
);
	import nsa_pkg::*;

	logic [N_STATES-1:0]   mask_q [NUM_SYMBOLS];
	logic                  active_q;
	logic                  eff;

	// mask store write
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mask_q[wr.sym] <= wr.mask;
		end
	end

	// add this state's targets to the running union
	always_comb begin
		eff       = ctl.start ? init_bit : active_q;
		union_out = union_in | (eff ? mask_q[ctl.pos] : '0);
	end

	// active bit takes the completed union from the end of the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (ctl.clear) begin
			active_q <= 1'b0;
		end else if (ctl.step) begin
			active_q <= ctl.hit & fin_bit;
		end
	end

	assign active = active_q;

endmodule

### rtl/nfa_string_acceptor.sv
// nfa_string_acceptor: nfa acceptance by state-set simulation over a row of state cells
// the result of an end-of-string word is registered and valid in the cycle after it is taken
// throughput: one word per cycle; a character updates every state cell in that cycle
// through the or-chain of target masks; an end-of-string word stalls while a result waits
// reset: clears the active set, the in-string flag and the result valid, sets the config
// registers to their reset values; alphabet and mask tables are not cleared and hold nothing until loaded

module nfa_string_acceptor (
	input  logic                               clk,
	input  logic                               arst_n,
	// input words
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         op,
	input  logic [nsa_pkg::CHAR_W-1:0]         character,
	input  logic [3:0]                         state_index,
	input  logic [2:0]                         symbol_index,
	input  logic [nsa_pkg::N_STATES-1:0]       target_mask,
	// result words
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               accepted,
	output logic [nsa_pkg::N_STATES-1:0]       active_states,
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [nsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nsa_pkg::CFG_W-1:0]          cfg_data
);
	import nsa_pkg::*;

	logic [CFG_W-1:0]      start_q;
	logic [CFG_W-1:0]      accept_q;
	logic [CFG_W-1:0]      syms_q;
	logic                  in_string_q;
	logic                  out_valid_q;
	logic                  accepted_q;
	logic [N_STATES-1:0]   active_states_q;

	logic                  accept_in;
	logic                  is_char;
	logic                  is_end;
	logic                  is_mask;
	logic                  is_alpha;
	logic                  sym_ok;
	logic                  hit;
	logic [SYM_W-1:0]      pos;
	step_ctl_t             ctl;
	logic [N_STATES-1:0]   init_vec;
	logic [N_STATES-1:0]   active_vec;
	logic [N_STATES-1:0]   end_set;
	logic                  end_acc;
	logic [N_STATES-1:0]   union_chain [N_STATES+1];

	// handshakes
	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall & (op == OP_END);
	assign accept_in = in_valid & ~in_stall;

	// opcode decode
	always_comb begin
		is_char  = 1'b0;
		is_end   = 1'b0;
		is_mask  = 1'b0;
		is_alpha = 1'b0;
		unique case (op)
			OP_CHAR:  is_char  = accept_in;
			OP_END:   is_end   = accept_in;
			OP_MASK:  is_mask  = accept_in;
			OP_ALPHA: is_alpha = accept_in;
			default:  ;
		endcase
	end

	assign sym_ok = int'(symbol_index) < NUM_SYMBOLS;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			accept_q <= '0;
			syms_q   <= SYMS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_START:  start_q  <= cfg_data;
				CFG_ACCEPT: accept_q <= cfg_data;
				CFG_SYMS:   syms_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	// character to symbol position
	nsa_alphabet u_alphabet (
		.clk     (clk),
		.wr_en   (is_alpha & sym_ok),
		.wr_pos  (symbol_index[SYM_W-1:0]),
		.wr_char (character),
		.ch      (character),
		.count   (syms_q),
		.hit     (hit),
		.pos     (pos)
	);

	// step control for the cell row
	always_comb begin
		ctl.step  = is_char;
		ctl.start = ~in_string_q;
		ctl.clear = is_end;
		ctl.hit   = hit;
		ctl.pos   = pos;
	end

	// row of state cells; the union travels from cell to cell
	assign union_chain[0] = '0;

	for (genvar s = 0; s < N_STATES; s++) begin : g_cell
		mask_wr_t wr;

		assign init_vec[s] = (int'(start_q) == s);

		always_comb begin
			wr.en   = is_mask & sym_ok & (int'(state_index) == s);
			wr.sym  = symbol_index[SYM_W-1:0];
			wr.mask = target_mask[N_STATES-1:0];
		end

		nsa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr        (wr),
			.ctl       (ctl),
			.init_bit  (init_vec[s]),
			.union_in  (union_chain[s]),
			.fin_bit   (union_chain[N_STATES][s]),
			.union_out (union_chain[s+1]),
			.active    (active_vec[s])
		);
	end

	// in-string flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q <= 1'b0;
		end else if (is_end) begin
			in_string_q <= 1'b0;
		end else if (is_char) begin
			in_string_q <= 1'b1;
		end
	end

	// end-of-string set and acceptance
	always_comb begin
		end_set = in_string_q ? active_vec : init_vec;
		end_acc = (int'(accept_q) < N_STATES) && end_set[accept_q[STATE_W-1:0]];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (is_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_end) begin
			accepted_q      <= end_acc;
			active_states_q <= end_set;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign active_states = active_states_q;

`ifndef ASSERT_OFF
	// a new result word only follows an accepted end-of-string word
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_valid && !in_stall && op == OP_END))
		else $error("result word without end of string");

	// the set and the string flag are cleared after an end of string
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		is_end |=> (!in_string_q && active_vec == '0))
		else $error("state not cleared after end of string");

	// a character outside the alphabet empties the set
	a_miss_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(is_char && !hit) |=> (active_vec == '0 && in_string_q))
		else $error("set not empty after unmatched character");

	// an accepting result always shows the final state active
	a_accept_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && accepted_q) |-> active_states_q[accept_q[STATE_W-1:0]])
		else $error("accepted without final state in set");
`endif

endmodule

### tb/nsa_checker.sv
// nsa_checker: watches the word, result and config channels of nfa_string_acceptor,
// predicts each result from its own copy of the tables and registers, and counts mismatches
// depends on nsa_pkg
`timescale 1ns / 1ps

module nsa_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [1:0]                     op,
	input  logic [nsa_pkg::CHAR_W-1:0]     character,
	input  logic [3:0]                     state_index,
	input  logic [2:0]                     symbol_index,
	input  logic [nsa_pkg::N_STATES-1:0]   target_mask,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           accepted,
	input  logic [nsa_pkg::N_STATES-1:0]   active_states,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [nsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nsa_pkg::CFG_W-1:0]      cfg_data,
	output int                             fail_count,
	output int                             outstanding
);
	import nsa_pkg::*;

	typedef struct packed {
		logic                  acc;
		logic [N_STATES-1:0]   states;
	} verdict_t;

	// shadow of the automaton tables, registers and running state set
	logic [N_STATES-1:0]   mask_mem [N_STATES*NUM_SYMBOLS];
	logic [CHAR_W-1:0]     alpha_mem [NUM_SYMBOLS];
	logic [N_STATES-1:0]   live_set;
	logic                  mid_string;
	logic [CFG_W-1:0]      start_reg;
	logic [CFG_W-1:0]      accept_reg;
	logic [CFG_W-1:0]      syms_reg;
	verdict_t              verdict_q[$];

	// set that a new string begins from; empty when the start names no state
	function automatic logic [N_STATES-1:0] entry_set();
		logic [N_STATES-1:0] s;
		s = '0;
		if (int'(start_reg) < N_STATES)
			s[start_reg] = 1'b1;
		return s;
	endfunction

	// one character step: lowest matching alphabet slot, then union of target masks
	function automatic logic [N_STATES-1:0] advance_set(logic [CHAR_W-1:0] ch);
		int                    limit;
		int                    hit_pos;
		logic [N_STATES-1:0]   nxt;
		limit = (int'(syms_reg) > NUM_SYMBOLS) ? NUM_SYMBOLS : int'(syms_reg);
		hit_pos = -1;
		for (int p = 0; p < limit; p++)
			if (hit_pos < 0 && alpha_mem[p] == ch)
				hit_pos = p;
		nxt = '0;
		if (hit_pos >= 0)
			for (int s = 0; s < N_STATES; s++)
				if (live_set[s])
					nxt |= mask_mem[s*NUM_SYMBOLS + hit_pos];
		return nxt;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			live_set   = '0;
			mid_string = 1'b0;
			start_reg  = '0;
			accept_reg = '0;
			syms_reg   = SYMS_RESET;
			verdict_q.delete();
			outstanding = 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START:  start_reg  = cfg_data;
					CFG_ACCEPT: accept_reg = cfg_data;
					CFG_SYMS:   syms_reg   = cfg_data;
					default: ;
				endcase
			end

			// result words against the oldest prediction
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$error("result word with none expected: accepted %0d, active_states %h",
						accepted, active_states);
					fail_count++;
				end else begin
					want = verdict_q.pop_front();
					if (accepted !== want.acc) begin
						$error("accepted: expected %0d, got %0d", want.acc, accepted);
						fail_count++;
					end
					if (active_states !== want.states) begin
						$error("active_states: expected %h, got %h", want.states, active_states);
						fail_count++;
					end
				end
			end

			// input words
			if (in_valid && !in_stall) begin
				case (op)
					OP_CHAR: begin
						if (!mid_string) begin
							live_set   = entry_set();
							mid_string = 1'b1;
						end
						live_set = advance_set(character);
					end
					OP_END: begin
						if (!mid_string)
							live_set = entry_set();
						want.acc    = (int'(accept_reg) < N_STATES) && live_set[accept_reg];
						want.states = live_set;
						verdict_q.push_back(want);
						live_set   = '0;
						mid_string = 1'b0;
					end
					OP_MASK: begin
						if (int'(state_index) < N_STATES && int'(symbol_index) < NUM_SYMBOLS)
							mask_mem[int'(state_index)*NUM_SYMBOLS + int'(symbol_index)] =
								target_mask;
					end
					default: begin
						if (int'(symbol_index) < NUM_SYMBOLS)
							alpha_mem[symbol_index] = character;
					end
				endcase
			end
			outstanding = verdict_q.size();
		end
	end

endmodule

### tb/testbench.sv
// testbench: drives words and register writes into nfa_string_acceptor with random gaps
// and result stalls; nsa_checker does the prediction, this module gives the verdict
// depends on nsa_pkg, nsa_checker and the rtl
`timescale 1ns / 1ps

module testbench;
	import nsa_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [CHAR_W-1:0]    CHAR_A    = "a";

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            op;
	logic [CHAR_W-1:0]     character;
	logic [3:0]            state_index;
	logic [2:0]            symbol_index;
	logic [N_STATES-1:0]   target_mask;
	logic                  out_valid;
	logic                  out_stall;
	logic                  accepted;
	logic [N_STATES-1:0]   active_states;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	int                    fail_count;
	int                    outstanding;

	// stimulus bookkeeping
	logic [CHAR_W-1:0] alpha_shadow [NUM_SYMBOLS];
	int                cur_syms;
	int                items_sent;
	bit                calm;

	nfa_string_acceptor u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .character(character),
		.state_index(state_index), .symbol_index(symbol_index), .target_mask(target_mask),
		.out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
		.active_states(active_states),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	nsa_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .character(character),
		.state_index(state_index), .symbol_index(symbol_index), .target_mask(target_mask),
		.out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
		.active_states(active_states),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop
	initial begin
		#(20_000_000);
		$display("testbench: FAIL");
		$finish;
	end

	// idle length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// target masks: mostly sparse so state sets stay interesting
	function automatic logic [N_STATES-1:0] rand_mask();
		int                    r;
		logic [N_STATES-1:0]   m;
		r = $urandom_range(0, 9);
		m = '0;
		if (r < 4)
			m[$urandom_range(0, N_STATES-1)] = 1'b1;
		else if (r < 7)
			m = N_STATES'($urandom & $urandom);
		else if (r < 9)
			m = N_STATES'($urandom);
		return m;
	endfunction

	// characters: mostly from the live alphabet, some anything
	function automatic logic [CHAR_W-1:0] pick_char();
		int eff;
		eff = (cur_syms > NUM_SYMBOLS) ? NUM_SYMBOLS : cur_syms;
		if (eff == 0 || $urandom_range(0, 9) == 0)
			return CHAR_W'($urandom);
		return alpha_shadow[$urandom_range(0, eff-1)];
	endfunction

	// result side stall
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = idle_len();
			repeat (n) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			n = $urandom_range(1, 6);
			repeat (n) begin
				@(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// one input word, held until taken
	task automatic send_word(op_t o, logic [CHAR_W-1:0] ch, logic [3:0] si, logic [2:0] sym,
		logic [N_STATES-1:0] m);
		int gap;
		gap = idle_len();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		op           <= o;
		character    <= ch;
		state_index  <= si;
		symbol_index <= sym;
		target_mask  <= m;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic put_char(logic [CHAR_W-1:0] ch);
		send_word(OP_CHAR, ch, 4'($urandom), 3'($urandom), N_STATES'($urandom));
	endtask

	task automatic put_end();
		send_word(OP_END, CHAR_W'($urandom), 4'($urandom), 3'($urandom), N_STATES'($urandom));
	endtask

	task automatic put_mask(logic [3:0] si, logic [2:0] sym, logic [N_STATES-1:0] m);
		send_word(OP_MASK, CHAR_W'($urandom), si, sym, m);
	endtask

	task automatic put_alpha(logic [2:0] sym, logic [CHAR_W-1:0] ch);
		alpha_shadow[sym] = ch;
		send_word(OP_ALPHA, ch, 4'($urandom), sym, N_STATES'($urandom));
	endtask

	// register write on the config channel
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain: no word offered, then wait until every result is in
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(logic [CFG_W-1:0] s, logic [CFG_W-1:0] a, logic [CFG_W-1:0] n);
		settle();
		write_reg(CFG_START, s);
		write_reg(CFG_ACCEPT, a);
		write_reg(CFG_SYMS, n);
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_SPARE, CFG_W'($urandom));
		cur_syms = n;
	endtask

	// every mask of every state and symbol
	task automatic load_automaton();
		for (int si = 0; si < N_STATES; si++)
			for (int sym = 0; sym < NUM_SYMBOLS; sym++)
				put_mask(4'(si), 3'(sym), rand_mask());
	endtask

	// a string of random length with loads mixed in; now and then left open
	task automatic run_string();
		int                len;
		int                r;
		logic [2:0]        sym;
		logic [CHAR_W-1:0] ch;
		len = $urandom_range(0, 8);
		for (int k = 0; k < len; k++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				put_mask(4'($urandom), 3'($urandom), rand_mask());
			end else if (r < 12) begin
				sym = 3'($urandom);
				ch  = $urandom_range(0, 1) ? CHAR_W'($urandom) :
					CHAR_A + CHAR_W'($urandom_range(0, 7));
				put_alpha(sym, ch);
			end else begin
				put_char(pick_char());
			end
		end
		if ($urandom_range(0, 9) != 0)
			put_end();
	endtask

	// stimulus and verdict
	initial begin
		int target;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		op           = OP_CHAR;
		character    = '0;
		state_index  = '0;
		symbol_index = '0;
		target_mask  = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_START;
		cfg_data     = '0;
		cur_syms     = NUM_SYMBOLS;
		items_sent   = 0;
		calm         = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// tables first: alphabet with a repeated value and both byte extremes
		put_alpha(3'd0, CHAR_A);
		put_alpha(3'd1, "b");
		put_alpha(3'd2, 8'h00);
		put_alpha(3'd3, 8'hFF);
		put_alpha(3'd4, CHAR_A);
		put_alpha(3'd5, "c");
		put_alpha(3'd6, "d");
		put_alpha(3'd7, "e");
		load_automaton();
		put_mask(4'd0, 3'd0, '1);
		put_mask(4'd15, 3'd4, '0);

		// reset register values: empty string, plain strings, unknown character
		put_end();
		put_char(CHAR_A);
		put_end();
		put_char(CHAR_A);
		put_char(CHAR_A);
		put_end();
		put_char("z");
		put_end();
		put_char(8'h00);
		put_char(8'hFF);
		put_end();
		// loads in the middle of a string
		put_char(CHAR_A);
		put_mask(4'd3, 3'd1, 16'h8001);
		put_alpha(3'd5, "b");
		put_char("b");
		put_end();

		// last state as start and final, alphabet size zero then one, then clamped
		set_regs(4'd15, 4'd15, 4'd0);
		put_end();
		put_char(CHAR_A);
		put_end();
		set_regs(4'd0, 4'd15, 4'd1);
		put_char(CHAR_A);
		put_end();
		put_char("b");
		put_end();
		set_regs(4'd3, 4'd7, 4'd15);
		put_char("e");
		put_end();

		// random phases
		for (int ph = 0; ph < 10; ph++) begin
			calm = ($urandom_range(0, 3) == 0);
			case (ph)
				0: set_regs(4'd0, 4'd0, 4'd8);
				1: set_regs(4'd15, 4'd15, 4'd15);
				2: set_regs(4'd15, 4'd0, 4'd0);
				3: set_regs(4'd0, 4'd15, 4'd1);
				default: set_regs(CFG_W'($urandom), CFG_W'($urandom),
					($urandom_range(0, 4) == 0) ? CFG_W'($urandom) :
						CFG_W'($urandom_range(1, NUM_SYMBOLS)));
			endcase
			if (ph == 5)
				load_automaton();
			target = items_sent + 20;
			while (items_sent < target)
				run_string();
		end

		calm = 1'b0;
		settle();
		if (fail_count == 0 && outstanding == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
